/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion wrappers, clocked on clk_i and gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define SLC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("slc assertion failed");

// consequent holds in the same cycle as the antecedent
`define SLC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("slc assertion failed");

// consequent holds in the cycle after the antecedent
`define SLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("slc assertion failed");

`else

`define SLC_ASSERT_ALWAYS(label, cond)
`define SLC_ASSERT_SAME(label, ante, cons)
`define SLC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/slc_pkg.sv */
// ----------------------------------------------------------------------------
// slc_pkg
// shared widths, row record type and the sigmoid lookup table
// ----------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

  // field widths
  localparam int DATA_W = 16;            // Q4.12 inputs
  localparam int PROD_W = 2 * DATA_W;    // Q8.24 product
  localparam int DOT_W  = 40;            // Q16.24 dot product
  localparam int Z_W    = DOT_W + DATA_W; // Q.36 logit
  localparam int Z_FRAC = 36;
  localparam int LOSS_W = 32;            // Q16.16 loss sum
  localparam int CNT_W  = 17;            // row count
  localparam int TAB_W  = 16;            // Q0.16 table entry

  // row bound
  localparam int MAX_ROWS = 65536;
  localparam int CNT_MAX  = (1 << CNT_W) - 1;
  localparam int ROW_CAP  = (MAX_ROWS < CNT_MAX) ? MAX_ROWS : CNT_MAX;

  // sigmoid table, power of two entries over [-8,8)
  localparam int SIG_ENTRIES = 256;
  localparam int IDX_W       = $clog2(SIG_ENTRIES);

  // row queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // one finished row handed from front to back
  typedef struct packed {
    logic signed [DOT_W-1:0]  dot;
    logic signed [DATA_W-1:0] label;
    logic                     last_row;
  } slc_row_t;

  // push beat from front into the queue
  typedef struct packed {
    logic     vld;
    slc_row_t row;
  } slc_push_t;

  typedef logic [TAB_W-1:0] sig_table_t [SIG_ENTRIES];

  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] EINV_Q32 = 64'd1580030169;

  // upper product bits, (a*b) >> 32
  function automatic logic [63:0] mul_hi32(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[95:32];
  endfunction

  // restoring long division, elaboration only
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], n[i]};
      if (rem >= d) begin
        rem  = rem - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-a), a and result in Q32.32
  function automatic logic [63:0] exp_neg_q32(input logic [63:0] a);
    logic [63:0]        ip;
    logic [63:0]        f;
    logic [63:0]        term;
    logic [63:0]        e;
    logic signed [65:0] sum;
    ip   = a >> 32;
    f    = {32'b0, a[31:0]};
    term = ONE_Q32;
    sum  = $signed({2'b00, ONE_Q32});
    // taylor series of exp(-f), each term truncated
    term = mul_hi32(term, f) / 64'd1;  sum = sum - $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd2;  sum = sum + $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd3;  sum = sum - $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd4;  sum = sum + $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd5;  sum = sum - $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd6;  sum = sum + $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd7;  sum = sum - $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd8;  sum = sum + $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd9;  sum = sum - $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd10; sum = sum + $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd11; sum = sum - $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd12; sum = sum + $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd13; sum = sum - $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd14; sum = sum + $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd15; sum = sum - $signed({2'b00, term});
    term = mul_hi32(term, f) / 64'd16; sum = sum + $signed({2'b00, term});
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > $signed({2'b00, ONE_Q32})) begin
      sum = $signed({2'b00, ONE_Q32});
    end
    e = sum[63:0];
    // one factor of 1/e per integer unit, up to eight, rounded half up
    for (int k = 0; k < 8; k++) begin
      if (64'(k) < ip) begin
        e = (e * EINV_Q32 + 64'h0000_0000_8000_0000) >> 32;
      end
    end
    return e;
  endfunction

  // entry k sits at the bin midpoint (2k+1-N)*8/N
  function automatic sig_table_t build_sig_table();
    sig_table_t  t;
    int          num;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] den;
    logic [63:0] s;
    for (int k = 0; k < SIG_ENTRIES; k++) begin
      num = 2 * k + 1 - SIG_ENTRIES;
      mag = (num < 0) ? 64'(-num) : 64'(num);
      a   = (mag * (64'd8 << 32)) / 64'(SIG_ENTRIES);
      den = ONE_Q32 + exp_neg_q32(a);
      s   = div_u64((64'd1 << 48) + (den >> 1), den);
      if (num < 0) begin
        s = 64'd65536 - s;
      end else if (s > 64'd65535) begin
        s = 64'd65535;
      end
      t[k] = s[TAB_W-1:0];
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

/* rtl/slc_front.sv */
// ----------------------------------------------------------------------------
// slc_front
// takes item beats, multiplies coordinate by feature and accumulates the
// saturating dot product; a finished row is pushed into the row queue
// ----------------------------------------------------------------------------
`default_nettype none

module slc_front
  import slc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] particle_coord_i,
  input  logic signed [DATA_W-1:0] feature_value_i,
  input  logic signed [DATA_W-1:0] label_value_i,
  input  logic                     last_feature_i,
  input  logic                     last_row_i,
  input  logic                     q_full_i,
  output slc_push_t                push_o
);

  localparam int SUM_W = DOT_W + 1;
  localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
  localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};

  logic                     p_vld_q;
  logic signed [PROD_W-1:0] p_prod_q;
  logic signed [DATA_W-1:0] p_label_q;
  logic                     p_lastf_q;
  logic                     p_lastr_q;
  logic signed [DOT_W-1:0]  dot_q;
  logic signed [DOT_W-1:0]  dot_d;
  logic signed [SUM_W-1:0]  dot_sum;
  logic signed [DOT_W-1:0]  dot_sat;
  logic                     p_adv;
  logic                     accept;
  logic                     fire;

  // product stage holds only when a row end meets a full queue
  assign p_adv      = !(p_vld_q && p_lastf_q && q_full_i);
  assign in_stall_o = !p_adv;
  assign accept     = in_valid_i && p_adv;
  assign fire       = p_vld_q && p_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (p_adv) begin
      p_vld_q <= in_valid_i;
    end
  end

  // product stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_prod_q  <= PROD_W'(particle_coord_i) * PROD_W'(feature_value_i);
      p_label_q <= label_value_i;
      p_lastf_q <= last_feature_i;
      p_lastr_q <= last_row_i;
    end
  end

  // saturating accumulate
  always_comb begin
    dot_sum = SUM_W'(dot_q) + SUM_W'(p_prod_q);
    if (dot_sum[SUM_W-1] != dot_sum[SUM_W-2]) begin
      dot_sat = dot_sum[SUM_W-1] ? DOT_MIN : DOT_MAX;
    end else begin
      dot_sat = dot_sum[DOT_W-1:0];
    end
  end

  // dot product restarts after every row end
  always_comb begin
    dot_d = dot_q;
    if (fire) begin
      dot_d = p_lastf_q ? '0 : dot_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
    end else begin
      dot_q <= dot_d;
    end
  end

  // row push toward the back
  always_comb begin
    push_o.vld          = fire && p_lastf_q;
    push_o.row.dot      = dot_sat;
    push_o.row.label    = p_label_q;
    push_o.row.last_row = p_lastr_q;
  end

endmodule

`default_nettype wire

/* rtl/slc_queue.sv */
// ----------------------------------------------------------------------------
// slc_queue
// short fifo of finished rows between front and back
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slc_queue
  import slc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  slc_push_t push_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      empty_o,
  output slc_row_t  data_o
);

  slc_row_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q;
  logic [Q_PTR_W-1:0]   rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q;
  logic                 push;

  assign push    = push_i.vld;
  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.row;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + Q_CNT_W'(1);
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - Q_CNT_W'(1);
      end
    end
  end

  `SLC_ASSERT_SAME(a_no_push_full, push, !full_o)
  `SLC_ASSERT_SAME(a_no_pop_empty, pop_i, !empty_o)

endmodule

`default_nettype wire

/* rtl/slc_back.sv */
// ----------------------------------------------------------------------------
// slc_back
// per row: logit multiply, clamp and table lookup, saturating loss sum;
// the last row loads the result register and clears the running state
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slc_back
  import slc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  slc_row_t          q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [LOSS_W-1:0] loss_total_o,
  output logic [CNT_W-1:0]  rows_counted_o,
  output logic              saturated_o
);

  localparam logic signed [Z_W-1:0] Z_HI = Z_W'(64'sd1 << (Z_FRAC + 3));
  localparam logic signed [Z_W-1:0] Z_LO = -Z_HI;
  localparam int IDX_MSB = Z_FRAC + 3;

  logic                    back_adv;
  logic                    pop;
  logic signed [Z_W-1:0]   dot_ext;
  logic signed [Z_W-1:0]   lab_ext;
  // logit stage
  logic                    z_vld_q;
  logic signed [Z_W-1:0]   z_q;
  logic                    z_last_q;
  // lookup stage
  logic [Z_W-1:0]          z_off;
  logic [IDX_W-1:0]        idx;
  logic                    t_vld_q;
  logic [TAB_W-1:0]        t_val_q;
  logic                    t_last_q;
  // accumulate stage
  logic                    acc_fire;
  logic                    row_over;
  logic [LOSS_W:0]         loss_sum;
  logic [LOSS_W-1:0]       loss_q;
  logic [LOSS_W-1:0]       loss_n;
  logic [CNT_W-1:0]        rows_q;
  logic [CNT_W-1:0]        rows_n;
  logic                    ovf_q;
  logic                    ovf_n;
  // result register
  logic                    out_vld_q;
  logic [LOSS_W-1:0]       out_loss_q;
  logic [CNT_W-1:0]        out_rows_q;
  logic                    out_sat_q;

  // whole back pipe holds while a result beat waits
  assign back_adv = !(out_vld_q && out_stall_i);
  assign pop      = back_adv && !q_empty_i;
  assign q_pop_o  = pop;
  assign acc_fire = t_vld_q && back_adv;

  // logit multiply
  assign dot_ext = Z_W'(q_data_i.dot);
  assign lab_ext = Z_W'(q_data_i.label);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_vld_q <= 1'b0;
      t_vld_q <= 1'b0;
    end else if (back_adv) begin
      z_vld_q <= pop;
      t_vld_q <= z_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      z_q      <= dot_ext * lab_ext;
      z_last_q <= q_data_i.last_row;
    end
  end

  // clamp to [-8,8) and index the table
  always_comb begin
    z_off = z_q - Z_LO;
    if (z_q < Z_LO) begin
      idx = '0;
    end else if (z_q >= Z_HI) begin
      idx = '1;
    end else begin
      idx = z_off[IDX_MSB -: IDX_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_adv) begin
      t_val_q  <= SIG_TABLE[idx];
      t_last_q <= z_last_q;
    end
  end

  // saturating loss sum and row bound
  always_comb begin
    row_over = (rows_q >= CNT_W'(ROW_CAP));
    loss_sum = {1'b0, loss_q} + (LOSS_W + 1)'(t_val_q);
    if (row_over) begin
      loss_n = '1;
      ovf_n  = 1'b1;
      rows_n = rows_q;
    end else begin
      loss_n = loss_sum[LOSS_W] ? '1 : loss_sum[LOSS_W-1:0];
      ovf_n  = ovf_q | loss_sum[LOSS_W];
      rows_n = rows_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_q <= '0;
      rows_q <= '0;
      ovf_q  <= 1'b0;
    end else if (acc_fire) begin
      if (t_last_q) begin
        loss_q <= '0;
        rows_q <= '0;
        ovf_q  <= 1'b0;
      end else begin
        loss_q <= loss_n;
        rows_q <= rows_n;
        ovf_q  <= ovf_n;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (back_adv) begin
      out_vld_q <= acc_fire && t_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_fire && t_last_q) begin
      out_loss_q <= loss_n;
      out_rows_q <= rows_n;
      out_sat_q  <= ovf_n;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign loss_total_o   = out_loss_q;
  assign rows_counted_o = out_rows_q;
  assign saturated_o    = out_sat_q;

  `SLC_ASSERT_ALWAYS(a_rows_cap, rows_q <= CNT_W'(ROW_CAP))
  `SLC_ASSERT_NEXT(a_clear_after_last, acc_fire && t_last_q, rows_q == '0 && loss_q == '0 && !ovf_q)
  `SLC_ASSERT_SAME(a_result_has_rows, out_vld_q, out_rows_q != '0)

endmodule

`default_nettype wire

/* rtl/sigmoid_loss_accumulator.sv */
// ----------------------------------------------------------------------------
// sigmoid_loss_accumulator
// Input channel: one beat per (particle_coord, feature_value) pair of a data
//   row, with label_value, last_feature and last_row alongside. The label is
//   taken on the beat that carries last_feature; last_row counts only there.
// Output channel: one beat per data set, on the row that carries last_row:
//   loss_total (Q16.16 sum of sigmoid table values, saturating),
//   rows_counted and saturated.
// Throughput: one input beat per cycle. A row end needs a free slot in the
//   two-entry row queue; the back retires one row per cycle while no result
//   beat is held, so the front only stalls while the receiver holds it.
// Result path: the closing input beat passes product and accumulate, the row
//   queue, logit multiply, lookup and sum; then the result beat shows valid.
// Reset: dot product, loss sum, row count and flag clear; no beats pending.
// Receiver stall: the result register holds, the back pipe freezes, the
//   queue fills and then in_stall_o rises at the next row end.
// ----------------------------------------------------------------------------
`default_nettype none

module sigmoid_loss_accumulator
  import slc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] particle_coord_i,
  input  logic signed [DATA_W-1:0] feature_value_i,
  input  logic signed [DATA_W-1:0] label_value_i,
  input  logic                     last_feature_i,
  input  logic                     last_row_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [LOSS_W-1:0]        loss_total_o,
  output logic [CNT_W-1:0]         rows_counted_o,
  output logic                     saturated_o
);

  slc_push_t push;
  slc_row_t  q_data;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  // dot product front
  slc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .particle_coord_i (particle_coord_i),
    .feature_value_i  (feature_value_i),
    .label_value_i    (label_value_i),
    .last_feature_i   (last_feature_i),
    .last_row_i       (last_row_i),
    .q_full_i         (q_full),
    .push_o           (push)
  );

  // finished rows
  slc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_data)
  );

  // sigmoid lookup and loss sum
  slc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .loss_total_o   (loss_total_o),
    .rows_counted_o (rows_counted_o),
    .saturated_o    (saturated_o)
  );

endmodule

`default_nettype wire
